// File: src/jack_lexer_token_stream_top_assert.svh
// Assertion macros used by the checker file.
`ifndef JACK_LEXER_TOKEN_STREAM_TOP_ASSERT_SVH
`define JACK_LEXER_TOKEN_STREAM_TOP_ASSERT_SVH
// Same-cycle implication.
`define JLTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jlts check failed");
// Next-cycle implication.
`define JLTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jlts check failed");
`endif

// File: src/jlts_pkg.sv
// ----------------------------------------------------------------------------
// jlts_pkg
// Shared types and constants of the Jack token stream lexer.
// ----------------------------------------------------------------------------
package jlts_pkg;

    localparam int MAX_RES = 4;
    localparam int NUM_KW  = 17;

    localparam logic KIND_VALUE = 1'b0;
    localparam logic KIND_MARK  = 1'b1;

    localparam logic [2:0] TK_KEYWORD = 3'd0;
    localparam logic [2:0] TK_IDENT   = 3'd1;
    localparam logic [2:0] TK_INTEGER = 3'd2;
    localparam logic [2:0] TK_SYMBOL  = 3'd3;
    localparam logic [2:0] TK_STRING  = 3'd4;
    localparam logic [2:0] TK_CHAR    = 3'd5;
    localparam logic [2:0] TK_ERROR   = 3'd6;
    localparam logic [2:0] TK_EOF     = 3'd7;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    typedef enum logic [13:0] {
        LX_START    = 14'h0001,
        LX_INT      = 14'h0002,
        LX_ID       = 14'h0004,
        LX_STR      = 14'h0008,
        LX_STR_ESC  = 14'h0010,
        LX_CHR      = 14'h0020,
        LX_CHR_A    = 14'h0040,
        LX_CHR_B    = 14'h0080,
        LX_CHR_C    = 14'h0100,
        LX_SYM      = 14'h0200,
        LX_ERR      = 14'h0400,
        LX_BLK      = 14'h0800,
        LX_BLK_STAR = 14'h1000,
        LX_LINE     = 14'h2000
    } lx_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] value_byte;
        logic [2:0] token_kind;
        logic [15:0] token_row;
    } jlts_entry_t;

    // Results of one input word, in order.
    typedef struct packed {
        logic [2:0]                  cnt;
        jlts_entry_t [MAX_RES-1:0]   ent;
    } jlts_bundle_t;

    // Keyword text, right-justified.
    localparam logic [95:0] KW_TEXT [NUM_KW] = '{
        96'("class"), 96'("constructor"), 96'("function"), 96'("method"),
        96'("field"), 96'("static"), 96'("int"), 96'("char"), 96'("boolean"),
        96'("void"), 96'("true"), 96'("false"), 96'("this"), 96'("if"),
        96'("else"), 96'("while"), 96'("return")};
    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd11, 4'd8, 4'd6, 4'd5, 4'd6, 4'd3, 4'd4, 4'd7,
        4'd4, 4'd4, 4'd5, 4'd4, 4'd2, 4'd4, 4'd5, 4'd6};

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] n);
        logic [95:0] s;
        logic [3:0]  l;
        begin
            s = KW_TEXT[k];
            l = KW_LEN[k];
            kw_char = 8'h00;
            if (n < l)
                kw_char = s[8*(int'(l) - 1 - int'(n)) +: 8];
        end
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c inside {CH_SPACE, CH_TAB, CH_NL});
    endfunction

    // { } ( ) [ ] . , ; + - * / & | ~ < > =
    function automatic logic is_sym(input logic [7:0] c);
        return (c inside {8'h7B, 8'h7D, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h2E, 8'h2C,
                          8'h3B, 8'h2B, 8'h2D, CH_STAR, CH_SLASH, CH_AMP, CH_BAR,
                          8'h7E, CH_LT, 8'h3E, CH_EQ});
    endfunction

    function automatic logic is_esc(input logic [7:0] c);
        return (c inside {8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76,
                          CH_BSLASH, CH_QMARK, CH_SQUOTE, CH_DQUOTE});
    endfunction

    function automatic jlts_bundle_t put_b(input jlts_bundle_t b, input logic [7:0] c);
        jlts_bundle_t r;
        begin
            r = b;
            if (b.cnt < 3'(MAX_RES)) begin
                r.ent[b.cnt[1:0]] = '{KIND_VALUE, c, 3'd0, 16'd0};
                r.cnt = b.cnt + 3'd1;
            end
            return r;
        end
    endfunction

    function automatic jlts_bundle_t put_m(input jlts_bundle_t b, input logic [2:0] k,
                                          input logic [15:0] row);
        jlts_bundle_t r;
        begin
            r = b;
            if (b.cnt < 3'(MAX_RES)) begin
                r.ent[b.cnt[1:0]] = '{KIND_MARK, 8'h00, k, row};
                r.cnt = b.cnt + 3'd1;
            end
            return r;
        end
    endfunction

endpackage

// File: src/jlts_front.sv
// ----------------------------------------------------------------------------
// jlts_front
// Accepts source words, runs the lexer state machine, builds result bundles.
// ----------------------------------------------------------------------------
module jlts_front
    import jlts_pkg::*;
#(
    parameter int ROW_WIDTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [7:0]   byte_in,
    input  logic         end_of_input,
    input  logic         q_full,
    output logic         q_push,
    output jlts_bundle_t q_data
);

    typedef struct packed {
        lx_state_t            state;
        logic [ROW_WIDTH-1:0] start_row;
        logic [7:0]           first_symbol;
        logic [7:0]           held0;
        logic [7:0]           held1;
        logic [NUM_KW-1:0]    kw_alive;
        logic [3:0]           ident_len;
    } lex_t;

    typedef struct packed {
        lex_t         s;
        jlts_bundle_t b;
        logic         again;
    } step_t;

    lex_t                 lex_reg, lex_next;
    logic [ROW_WIDTH-1:0] line_reg, line_next;
    logic                 als_reg, als_next;
    logic                 accept;
    step_t                r1, r2;

    function automatic logic [15:0] row16(input logic [ROW_WIDTH-1:0] r);
        logic [31:0] w;
        begin
            w = 32'(r);
            return w[15:0];
        end
    endfunction

    function automatic lex_t kw_adv(input lex_t s, input logic [7:0] c);
        lex_t              r;
        logic [NUM_KW-1:0] keep;
        begin
            r    = s;
            keep = '0;
            if (s.ident_len < 4'd11)
                for (int k = 0; k < NUM_KW; k++)
                    keep[k] = (kw_char(k, s.ident_len) == c);
            r.kw_alive = s.kw_alive & keep;
            if (s.ident_len < 4'd15)
                r.ident_len = s.ident_len + 4'd1;
            return r;
        end
    endfunction

    function automatic logic kw_hit(input lex_t s);
        logic h;
        begin
            h = 1'b0;
            for (int k = 0; k < NUM_KW; k++)
                if (s.kw_alive[k] && KW_LEN[k] == s.ident_len)
                    h = 1'b1;
            return h;
        end
    endfunction

    function automatic step_t lex_one(input lex_t s, input logic [7:0] c,
                                      input jlts_bundle_t b,
                                      input logic [ROW_WIDTH-1:0] line);
        step_t       r;
        logic [15:0] srow;
        logic [7:0]  f;
        begin
            r.s     = s;
            r.b     = b;
            r.again = 1'b0;
            srow    = row16(s.start_row);
            f       = s.first_symbol;
            case (s.state)
                LX_START:
                begin
                    if (!is_space(c))
                    begin
                        r.s.start_row = line;
                        if (is_alpha(c) || c == CH_UNDER)
                        begin
                            r.s.state     = LX_ID;
                            r.s.kw_alive  = '1;
                            r.s.ident_len = 4'd0;
                            r.s           = kw_adv(r.s, c);
                            r.b           = put_b(r.b, c);
                        end
                        else if (is_digit(c))
                        begin
                            r.s.state = LX_INT;
                            r.b       = put_b(r.b, c);
                        end
                        else if (is_sym(c))
                        begin
                            r.s.state        = LX_SYM;
                            r.s.first_symbol = c;
                        end
                        else if (c == CH_DQUOTE)
                            r.s.state = LX_STR;
                        else if (c == CH_SQUOTE)
                            r.s.state = LX_CHR;
                        else
                        begin
                            r.s.state = LX_ERR;
                            r.b       = put_b(r.b, c);
                        end
                    end
                end
                LX_INT:
                begin
                    if (is_digit(c))
                        r.b = put_b(r.b, c);
                    else
                    begin
                        r.b       = put_m(r.b, TK_INTEGER, srow);
                        r.s.state = LX_START;
                        r.again   = 1'b1;
                    end
                end
                LX_ID:
                begin
                    if (is_alpha(c) || is_digit(c) || c == CH_UNDER)
                    begin
                        r.s = kw_adv(s, c);
                        r.b = put_b(r.b, c);
                    end
                    else
                    begin
                        r.b       = put_m(r.b, kw_hit(s) ? TK_KEYWORD : TK_IDENT, srow);
                        r.s.state = LX_START;
                        r.again   = 1'b1;
                    end
                end
                LX_STR:
                begin
                    if (c == CH_DQUOTE)
                    begin
                        r.b       = put_m(r.b, TK_STRING, srow);
                        r.s.state = LX_START;
                    end
                    else if (c == CH_BSLASH)
                        r.s.state = LX_STR_ESC;
                    else
                        r.b = put_b(r.b, c);
                end
                LX_STR_ESC:
                begin
                    r.b       = put_b(r.b, c);
                    r.s.state = LX_STR;
                end
                LX_CHR:
                begin
                    if (c == CH_SQUOTE)
                    begin
                        r.b       = put_b(put_b(r.b, c), c);
                        r.s.state = LX_ERR;
                    end
                    else
                    begin
                        r.s.held0 = c;
                        r.s.state = (c == CH_BSLASH) ? LX_CHR_B : LX_CHR_A;
                    end
                end
                LX_CHR_A:
                begin
                    if (c == CH_SQUOTE)
                    begin
                        r.b       = put_m(put_b(r.b, s.held0), TK_CHAR, srow);
                        r.s.state = LX_START;
                    end
                    else
                    begin
                        r.b       = put_b(put_b(put_b(r.b, CH_SQUOTE), s.held0), c);
                        r.s.state = LX_ERR;
                    end
                end
                LX_CHR_B:
                begin
                    if (is_esc(c))
                    begin
                        r.s.held1 = c;
                        r.s.state = LX_CHR_C;
                    end
                    else
                    begin
                        r.b       = put_b(put_b(put_b(r.b, CH_SQUOTE), CH_BSLASH), c);
                        r.s.state = LX_ERR;
                    end
                end
                LX_CHR_C:
                begin
                    if (c == CH_SQUOTE)
                    begin
                        r.b = put_m(put_b(put_b(r.b, CH_BSLASH), s.held1), TK_CHAR, srow);
                        r.s.state = LX_START;
                    end
                    else
                    begin
                        r.b = put_b(put_b(put_b(put_b(r.b, CH_SQUOTE), CH_BSLASH),
                                          s.held1), c);
                        r.s.state = LX_ERR;
                    end
                end
                LX_SYM:
                begin
                    if (f == CH_SLASH && c == CH_STAR)
                        r.s.state = LX_BLK;
                    else if (f == CH_SLASH && c == CH_SLASH)
                        r.s.state = LX_LINE;
                    else if (((f == CH_LT || f == CH_EQ) && c == CH_EQ) ||
                             (f == CH_AMP && c == CH_AMP) || (f == CH_BAR && c == CH_BAR))
                    begin
                        r.b       = put_m(put_b(put_b(r.b, f), c), TK_SYMBOL, srow);
                        r.s.state = LX_START;
                    end
                    else
                    begin
                        r.b       = put_m(put_b(r.b, f), TK_SYMBOL, srow);
                        r.s.state = LX_START;
                        r.again   = 1'b1;
                    end
                end
                LX_ERR:
                begin
                    if (is_space(c))
                    begin
                        r.b       = put_m(r.b, TK_ERROR, srow);
                        r.s.state = LX_START;
                    end
                    else
                        r.b = put_b(r.b, c);
                end
                LX_BLK:
                begin
                    if (c == CH_STAR)
                        r.s.state = LX_BLK_STAR;
                end
                LX_BLK_STAR:
                begin
                    if (c == CH_SLASH)
                        r.s.state = LX_START;
                    else if (c != CH_STAR)
                        r.s.state = LX_BLK;
                end
                LX_LINE:
                begin
                    if (c == CH_NL)
                        r.s.state = LX_START;
                end
                default:
                    r.s.state = LX_START;
            endcase
            return r;
        end
    endfunction

    function automatic step_t lex_eof(input lex_t s, input logic [ROW_WIDTH-1:0] line);
        step_t       r;
        logic [15:0] row;
        begin
            r.s     = s;
            r.b     = '0;
            r.again = 1'b0;
            row     = (s.state == LX_START) ? row16(line) : row16(s.start_row);
            case (s.state)
                LX_SYM:     r.b = put_b(r.b, s.first_symbol);
                LX_CHR_A:   r.b = put_b(r.b, s.held0);
                LX_CHR_B:   r.b = put_b(r.b, CH_BSLASH);
                LX_CHR_C:   r.b = put_b(put_b(r.b, CH_BSLASH), s.held1);
                LX_STR_ESC: r.b = put_b(r.b, CH_BSLASH);
                default:    r.b = r.b;
            endcase
            r.b           = put_m(r.b, TK_EOF, row);
            r.s.state     = LX_START;
            r.s.kw_alive  = '1;
            r.s.ident_len = 4'd0;
            return r;
        end
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        line_next = line_reg;
        als_next  = als_reg;
        r1        = '0;
        r2        = '0;
        if (end_of_input)
            r2 = lex_eof(lex_reg, line_reg);
        else
        begin
            if (als_reg && line_reg != '1)
                line_next = line_reg + 1'b1;
            als_next = (byte_in == CH_NL);
            r1 = lex_one(lex_reg, byte_in, '0, line_next);
            r2 = r1.again ? lex_one(r1.s, byte_in, r1.b, line_next) : r1;
        end
        lex_next = r2.s;
    end

    assign q_push = accept && (r2.b.cnt != 3'd0);
    assign q_data = r2.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_reg  <= '{LX_START, '0, 8'h00, 8'h00, 8'h00, '1, 4'd0};
            line_reg <= '0;
            als_reg  <= 1'b1;
        end
        else if (accept)
        begin
            lex_reg  <= lex_next;
            line_reg <= line_next;
            als_reg  <= als_next;
        end
    end

endmodule

// File: src/jlts_queue.sv
// ----------------------------------------------------------------------------
// jlts_queue
// Two-entry bundle queue between the lexer front and the output sequencer.
// ----------------------------------------------------------------------------
module jlts_queue
    import jlts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  jlts_bundle_t wr_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output jlts_bundle_t rd_data
);

    jlts_bundle_t mem_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/jlts_back.sv
// ----------------------------------------------------------------------------
// jlts_back
// Plays out a bundle's results, one word per unstalled cycle; flags the last.
// ----------------------------------------------------------------------------
module jlts_back
    import jlts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_not_empty,
    input  jlts_bundle_t q_data,
    output logic         q_pop,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         kind,
    output logic [7:0]   value_byte,
    output logic [2:0]   token_kind,
    output logic [15:0]  token_row,
    output logic         last
);

    jlts_bundle_t cur_reg;
    logic [1:0]   idx_reg, idx_next;
    logic         vld_reg, vld_next;
    logic         is_last;
    jlts_entry_t  e;

    assign e          = cur_reg.ent[idx_reg];
    assign is_last    = ({1'b0, idx_reg} + 3'd1 == cur_reg.cnt);
    assign out_valid  = vld_reg;
    assign kind       = e.kind;
    assign value_byte = e.value_byte;
    assign token_kind = e.token_kind;
    assign token_row  = e.token_row;
    assign last       = is_last;

    // Reload when empty or when the last word of the bundle leaves.
    assign q_pop = q_not_empty && (!vld_reg || (!out_stall && is_last));

    always_comb
    begin
        idx_next = idx_reg;
        vld_next = vld_reg;
        if (q_pop)
        begin
            idx_next = 2'd0;
            vld_next = 1'b1;
        end
        else if (vld_reg && !out_stall)
        begin
            if (is_last)
                vld_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            vld_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            vld_reg <= vld_next;
        end
    end

endmodule

// File: src/jack_lexer_token_stream_top.sv
// ----------------------------------------------------------------------------
// jack_lexer_token_stream_top
// Jack source tokenizer: bytes in, token text and token-end markers out.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one source byte per word, or an
//   end_of_input word that flushes held text and emits an end-of-file marker.
// Output channel (out_valid / out_stall): one result per word. kind 0 is a
//   text byte of the current token, kind 1 a marker carrying token_kind and
//   the token's start row. last flags the final result of an input word.
// An input word yields zero to four results. Comment bytes and whitespace
//   that neither ends a token nor lies in a string yield none; they are
//   absorbed at one byte per cycle while the queue is not full.
// Results pass a queue entry, then the output register of the sequencer.
// Throughput while out_stall is low: one input word per cycle if each makes
//   at most one result; otherwise the output paces at one result per cycle.
// The front (lexer state machine, line counter) and the back (sequencer)
//   are split by a two-bundle queue; in_stall rises only when it is full.
// When the receiver stalls, the current result holds and the queue fills.
// Reset: start state, row count zero, queue empty, out_valid low.
// ----------------------------------------------------------------------------
module jack_lexer_token_stream_top
    import jlts_pkg::*;
#(
    parameter int ROW_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  value_byte,
    output logic [2:0]  token_kind,
    output logic [15:0] token_row,
    output logic        last
);

    logic         q_push, q_full, q_pop, q_not_empty;
    jlts_bundle_t q_wr, q_rd;

    jlts_front #(.ROW_WIDTH(ROW_WIDTH)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .end_of_input (end_of_input),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_wr)
    );

    jlts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   (q_wr),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_rd)
    );

    jlts_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value_byte  (value_byte),
        .token_kind  (token_kind),
        .token_row   (token_row),
        .last        (last)
    );

endmodule

// File: src/jlts_checker.sv
// ----------------------------------------------------------------------------
// jlts_checker
// Port-level checks on the token stream output.
// ----------------------------------------------------------------------------
`include "jack_lexer_token_stream_top_assert.svh"
module jlts_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [7:0]  value_byte,
    input logic [2:0]  token_kind,
    input logic [15:0] token_row,
    input logic        last
);

    `JLTS_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid)
    // a stalled word keeps its payload
    `JLTS_ASSERT_NEXT(a_stable, out_valid && out_stall, $stable({kind, value_byte, token_kind, token_row, last}))
    // markers carry no text byte
    `JLTS_ASSERT_NOW(a_mark_clean, out_valid && kind, value_byte == 8'h00)
    // text bytes carry no kind or row
    `JLTS_ASSERT_NOW(a_text_clean, out_valid && !kind, token_kind == 3'd0 && token_row == 16'd0)

endmodule

bind jack_lexer_token_stream_top jlts_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value_byte (value_byte),
    .token_kind (token_kind),
    .token_row  (token_row),
    .last       (last)
);
